>>> rtl/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg
// Shared types and constants for the timestamp aligned demultiplexer.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int NumControlsDefault = 4;
    localparam int QueueDepthDefault  = 64;
    localparam int SyncRounds         = 2 * 64;
    localparam int MaskWidth          = 4;

    localparam logic [63:0] MagMask    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PosInfBits = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [2:0]         port;
        logic signed [63:0] stamp;
        logic [63:0]        value;
    } in_item_t;

    typedef struct packed {
        logic               synced;
        logic signed [63:0] out_stamp;
        logic [3:0]         emit_mask;
        logic [63:0]        data_value;
        logic               overflow;
    } out_item_t;

    // Ordered not-equal to 0.0: false for +-0 and NaN.
    function automatic logic ordered_nonzero(input logic [63:0] bits);
        logic [63:0] mag;
        mag = bits & MagMask;
        return (mag != 64'd0) && (mag <= PosInfBits);
    endfunction

endpackage

>>> rtl/timestamp_aligned_demultiplexer_core.sv
// ----------------------------------------------------------------------------
// timestamp_aligned_demultiplexer_core
// Pushes each item into the data or a control FIFO, then runs one sync pass.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | tad_pkg::in_item_t
//  out     | output    | out_valid/out_ready| tad_pkg::out_item_t
//
// Each compare and each drop round read the queue fronts through the single
// memory read port, one front at a time (an address state, then a data state);
// an item that finds a control queue empty skips these reads. While out_ready
// stays low the result is held.
// Reset clears all heads and counts; memory contents need no clearing.
// The input is held off while an item is in work or its result waits.
// ----------------------------------------------------------------------------
module timestamp_aligned_demultiplexer_core #(
    parameter int NUM_CONTROLS = tad_pkg::NumControlsDefault,
    parameter int QUEUE_DEPTH  = tad_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tad_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tad_pkg::out_item_t  out_data
);

    localparam int NQ     = NUM_CONTROLS + 1;
    localparam int QW     = $clog2(NQ);
    localparam int HW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int MDEPTH = NQ * QUEUE_DEPTH;
    localparam int AW     = $clog2(MDEPTH);
    localparam int RW     = $clog2(tad_pkg::SyncRounds + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PUSH  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_RADDR = 4'd3;
    localparam logic [3:0] S_RDAT  = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_DROP  = 4'd6;
    localparam logic [3:0] S_DADDR = 4'd7;
    localparam logic [3:0] S_DDAT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [HW-1:0]       head_reg  [NQ];
    logic [CW-1:0]       count_reg [NQ];
    tad_pkg::in_item_t   item_reg;
    tad_pkg::out_item_t  res_reg;
    logic [QW-1:0]       idx_reg;
    logic [RW-1:0]       round_reg;
    logic signed [63:0]  mn_reg, mx_reg;
    logic [NQ-1:0]       is_min_reg;
    logic [63:0]         front_stamp_reg [NQ];
    logic [3:0]          mask_reg;

    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [127:0]        rd_data;
    logic [QW-1:0]       pq;
    logic                any_empty;
    logic signed [63:0]  rd_stamp;
    logic [63:0]         rd_value;
    logic [HW:0]         slot_sum;
    logic [HW-1:0]       slot;

    assign rd_stamp = rd_data[127:64];
    assign rd_value = rd_data[63:0];
    assign pq       = item_reg.port[QW-1:0];

    // Wrap head + count into the ring
    always_comb
    begin
        slot_sum = {1'b0, head_reg[pq]} + count_reg[pq][HW:0];
        if (slot_sum >= (HW+1)'(QUEUE_DEPTH))
            slot = HW'(slot_sum - (HW+1)'(QUEUE_DEPTH));
        else
            slot = slot_sum[HW-1:0];
    end

    assign wr_en   = (state_reg == S_PUSH) && (item_reg.port <= 3'(NUM_CONTROLS))
                     && (count_reg[pq] < CW'(QUEUE_DEPTH));
    assign wr_addr = AW'(pq * QUEUE_DEPTH) + AW'(slot);
    assign rd_addr = AW'(idx_reg * QUEUE_DEPTH) + AW'(head_reg[idx_reg]);

    // Any control queue empty
    always_comb
    begin
        any_empty = 1'b0;
        for (int i = 1; i < NQ; i++)
        begin
            if (count_reg[i] == '0)
                any_empty = 1'b1;
        end
    end

    tad_queue_mem #(
        .ADDR_W (AW),
        .DEPTH  (MDEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({item_reg.stamp, item_reg.value}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PUSH;
            S_PUSH:  state_next = S_CHK;
            S_CHK:
            begin
                if (any_empty || round_reg == RW'(tad_pkg::SyncRounds))
                    state_next = S_DONE;
                else
                    state_next = S_RADDR;
            end
            S_RADDR: state_next = S_RDAT;
            S_RDAT:
            begin
                if (idx_reg == QW'(NUM_CONTROLS))
                    state_next = S_EVAL;
                else
                    state_next = S_RADDR;
            end
            S_EVAL:
            begin
                if (mn_reg != mx_reg)
                    state_next = S_DROP;
                else if (count_reg[0] == '0)
                    state_next = S_DONE;
                else
                    state_next = S_DADDR;
            end
            S_DROP:  state_next = S_CHK;
            S_DADDR: state_next = S_DDAT;
            S_DDAT:
            begin
                // Stop after the data front unless it matches, else after the last control
                if (idx_reg == QW'(NUM_CONTROLS) || (idx_reg == '0 && rd_stamp != mn_reg))
                    state_next = S_DONE;
                else
                    state_next = S_DADDR;
            end
            S_DONE:  state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, queue pointers and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    item_reg  <= in_data;
                    round_reg <= '0;
                    res_reg   <= '0;
                end
                S_PUSH:
                begin
                    if (item_reg.port <= 3'(NUM_CONTROLS))
                    begin
                        if (wr_en)
                            count_reg[pq] <= count_reg[pq] + CW'(1);
                        else
                            res_reg.overflow <= 1'b1;
                    end
                end
                S_CHK:
                begin
                    idx_reg <= QW'(1);
                end
                S_RDAT:
                begin
                    // Fold one control front into min and max
                    front_stamp_reg[idx_reg] <= rd_stamp;
                    if (idx_reg == QW'(1) || rd_stamp < mn_reg)
                        mn_reg <= rd_stamp;
                    if (idx_reg == QW'(1) || rd_stamp > mx_reg)
                        mx_reg <= rd_stamp;
                    idx_reg <= idx_reg + QW'(1);
                end
                S_EVAL:
                begin
                    for (int i = 1; i < NQ; i++)
                        is_min_reg[i] <= (front_stamp_reg[i] == mn_reg);
                    is_min_reg[0] <= 1'b0;
                    idx_reg  <= '0;
                    mask_reg <= '0;
                end
                S_DROP:
                begin
                    // Pop every control at the minimum stamp
                    for (int i = 1; i < NQ; i++)
                    begin
                        if (is_min_reg[i])
                        begin
                            head_reg[i]  <= (head_reg[i] == HW'(QUEUE_DEPTH - 1))
                                            ? '0 : head_reg[i] + HW'(1);
                            count_reg[i] <= count_reg[i] - CW'(1);
                        end
                    end
                    round_reg <= round_reg + RW'(1);
                end
                S_DDAT:
                begin
                    if (idx_reg == '0)
                    begin
                        if (rd_stamp == mn_reg)
                        begin
                            res_reg.synced     <= 1'b1;
                            res_reg.out_stamp  <= mn_reg;
                            res_reg.data_value <= rd_value;
                        end
                        else if (rd_stamp < mn_reg)
                        begin
                            // Data older: drop data only
                            head_reg[0]  <= (head_reg[0] == HW'(QUEUE_DEPTH - 1))
                                            ? '0 : head_reg[0] + HW'(1);
                            count_reg[0] <= count_reg[0] - CW'(1);
                        end
                        else
                        begin
                            // Controls older: drop all controls
                            for (int i = 1; i < NQ; i++)
                            begin
                                head_reg[i]  <= (head_reg[i] == HW'(QUEUE_DEPTH - 1))
                                                ? '0 : head_reg[i] + HW'(1);
                                count_reg[i] <= count_reg[i] - CW'(1);
                            end
                        end
                    end
                    else if (int'(idx_reg) <= tad_pkg::MaskWidth)
                    begin
                        mask_reg[2'(idx_reg - QW'(1))] <= tad_pkg::ordered_nonzero(rd_value);
                    end
                    idx_reg <= idx_reg + QW'(1);
                end
                S_DONE:
                begin
                    // Match: drop every queue, publish mask
                    if (res_reg.synced)
                    begin
                        res_reg.emit_mask <= mask_reg;
                        for (int i = 0; i < NQ; i++)
                        begin
                            head_reg[i]  <= (head_reg[i] == HW'(QUEUE_DEPTH - 1))
                                            ? '0 : head_reg[i] + HW'(1);
                            count_reg[i] <= count_reg[i] - CW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.synced |-> out_data.emit_mask == '0
            && out_data.data_value == '0 && out_data.out_stamp == '0)
        else $error("unsynced result not zeroed");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] <= CW'(QUEUE_DEPTH))
        else $error("data queue count exceeds depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

endmodule

>>> rtl/tad_queue_mem.sv
// ----------------------------------------------------------------------------
// tad_queue_mem
// Entry storage for all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tad_queue_mem #(
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 320
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [127:0]      wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [127:0]      rd_data
);

    logic [127:0] mem [DEPTH];

    // Write and read the entry array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
